FILE: rtl/core/adm_pkg.sv
`timescale 1ns / 1ps

package adm_pkg;

    localparam int ADM_COUNT_BITS = 32;

    localparam int ADM_LINE_W  = 12;
    localparam int ADM_ACKS_W  = 8;
    localparam int ADM_STEP_W  = 8;
    localparam int ADM_HACK_W  = 8;
    localparam int ADM_STAT_W  = 32;
    localparam int ADM_CMD_W   = 3;
    localparam int ADM_INDEX_W = 2;
    localparam int ADM_DATA_W  = 12;

    localparam logic [ADM_ACKS_W-1:0] ADM_ACKS_RESET = 8'd8;
    localparam logic [ADM_STEP_W-1:0] ADM_STEP_RESET = 8'd1;

    typedef enum logic [ADM_INDEX_W-1:0] {
        REG_TOTAL_LINES   = 2'd0,
        REG_FIELD_BUFFER  = 2'd1,
        REG_ACKS_PER_STEP = 2'd2,
        REG_STEP_LINES    = 2'd3
    } reg_index_t;

    typedef enum logic [ADM_CMD_W-1:0] {
        CMD_HEALTHY       = 3'd0,
        CMD_UNHEALTHY     = 3'd1,
        CMD_MISSING       = 3'd2,
        CMD_PHASE_LOCK    = 3'd3,
        CMD_SET_AUTOMATIC = 3'd4,
        CMD_CONFIGURE     = 3'd5,
        CMD_RESET         = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [ADM_LINE_W-1:0] total_lines;
        logic                  field_buffer;
        logic [ADM_ACKS_W-1:0] acks_per_step;
        logic [ADM_STEP_W-1:0] step_lines;
    } cfg_t;

    typedef struct packed {
        logic                  eligible_now;
        logic [ADM_LINE_W-1:0] reserve_lines;
        logic [ADM_LINE_W-1:0] safe_line;
        logic [ADM_HACK_W-1:0] healthy_count;
        logic [ADM_STAT_W-1:0] reduction_count;
        logic [ADM_STAT_W-1:0] reset_count;
    } result_t;

endpackage

FILE: rtl/core/adm_cmd_if.sv
`timescale 1ns / 1ps

interface adm_cmd_if;
    import adm_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [ADM_CMD_W-1:0] cmd;
    logic                 automatic_value;

    modport source (output valid, output cmd, output automatic_value, input ready);
    modport sink   (input valid, input cmd, input automatic_value, output ready);
endinterface

FILE: rtl/core/adm_stat_if.sv
`timescale 1ns / 1ps

interface adm_stat_if;
    import adm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  eligible_now;
    logic [ADM_LINE_W-1:0] reserve_lines;
    logic [ADM_LINE_W-1:0] safe_line;
    logic [ADM_HACK_W-1:0] healthy_count;
    logic [ADM_STAT_W-1:0] reduction_count;
    logic [ADM_STAT_W-1:0] reset_count;

    modport source (
        output valid, output eligible_now, output reserve_lines, output safe_line,
        output healthy_count, output reduction_count, output reset_count,
        input ready
    );
    modport sink (
        input valid, input eligible_now, input reserve_lines, input safe_line,
        input healthy_count, input reduction_count, input reset_count,
        output ready
    );
endinterface

FILE: rtl/core/adm_cfg_regs.sv
`timescale 1ns / 1ps

module adm_cfg_regs
    import adm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [ADM_INDEX_W-1:0] cfg_index,
    input  logic [ADM_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.total_lines   <= '0;
            cfg_reg.field_buffer  <= 1'b0;
            cfg_reg.acks_per_step <= ADM_ACKS_RESET;
            cfg_reg.step_lines    <= ADM_STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_TOTAL_LINES:   cfg_reg.total_lines   <= cfg_data[ADM_LINE_W-1:0];
                REG_FIELD_BUFFER:  cfg_reg.field_buffer  <= cfg_data[0];
                REG_ACKS_PER_STEP: cfg_reg.acks_per_step <= cfg_data[ADM_ACKS_W-1:0];
                REG_STEP_LINES:    cfg_reg.step_lines    <= cfg_data[ADM_STEP_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/adm_margin_state.sv
`timescale 1ns / 1ps

module adm_margin_state
    import adm_pkg::*;
#(
    parameter int COUNT_BITS = ADM_COUNT_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 update,
    input  logic [ADM_CMD_W-1:0] cmd,
    input  logic                 automatic_value,
    input  cfg_t                 cfg,
    output result_t              result
);

    logic [ADM_LINE_W-1:0] captured_total_reg, captured_total_next;
    logic                  field_mode_on_reg, field_mode_on_next;
    logic                  automatic_on_reg, automatic_on_next;
    logic                  locked_flag_reg, locked_flag_next;
    logic [ADM_LINE_W-1:0] reserve_reg, reserve_next;
    logic [ADM_HACK_W-1:0] healthy_acks_reg, healthy_acks_next;
    logic [COUNT_BITS-1:0] reductions_reg, reductions_next;
    logic [COUNT_BITS-1:0] restores_reg, restores_next;

    logic [ADM_LINE_W-1:0] conservative;
    logic [ADM_LINE_W-1:0] minimum;
    logic [ADM_LINE_W-1:0] new_total;
    logic [ADM_LINE_W+1:0] triple;
    logic [ADM_HACK_W:0]   healthy_inc;
    logic [ADM_LINE_W:0]   floor_plus_step;
    logic                  eligible;
    logic                  eligible_next;

    // max(1, total/2), and zero while no total is captured
    function automatic logic [ADM_LINE_W-1:0] conservative_of(input logic [ADM_LINE_W-1:0] t);
        logic [ADM_LINE_W-1:0] half;
        half = {1'b0, t[ADM_LINE_W-1:1]};
        if (t == '0)
            return '0;
        else if (half == '0)
            return ADM_LINE_W'(1);
        else
            return half;
    endfunction

    always_comb
    begin
        conservative = conservative_of(captured_total_reg);
        triple  = {2'b00, captured_total_reg} + {1'b0, captured_total_reg, 1'b0};
        if (captured_total_reg == '0)
            minimum = '0;
        else if (triple[ADM_LINE_W+1:3] == '0)
            minimum = ADM_LINE_W'(1);
        else
            minimum = {1'b0, triple[ADM_LINE_W+1:3]};
        new_total = (cfg.field_buffer && cfg.total_lines != '0) ? cfg.total_lines : '0;
        healthy_inc = {1'b0, healthy_acks_reg} + (ADM_HACK_W+1)'(1);
        floor_plus_step = {1'b0, minimum} + {{(ADM_LINE_W+1-ADM_STEP_W){1'b0}}, cfg.step_lines};
        eligible = (captured_total_reg != '0) && field_mode_on_reg && automatic_on_reg
                   && locked_flag_reg;

        captured_total_next = captured_total_reg;
        field_mode_on_next  = field_mode_on_reg;
        automatic_on_next   = automatic_on_reg;
        locked_flag_next    = locked_flag_reg;
        reserve_next        = reserve_reg;
        healthy_acks_next   = healthy_acks_reg;
        reductions_next     = reductions_reg;
        restores_next       = restores_reg;

        unique case (cmd) inside
            CMD_HEALTHY, CMD_UNHEALTHY, CMD_MISSING:
            begin
                if (eligible)
                begin
                    if (cmd == CMD_MISSING)
                    begin
                        healthy_acks_next = '0;
                    end
                    else if (cmd == CMD_UNHEALTHY)
                    begin
                        if (reserve_reg != conservative || healthy_acks_reg != '0)
                            restores_next = restores_reg + COUNT_BITS'(1);
                        reserve_next      = conservative;
                        healthy_acks_next = '0;
                    end
                    else if (healthy_inc < {1'b0, cfg.acks_per_step})
                    begin
                        healthy_acks_next = healthy_inc[ADM_HACK_W-1:0];
                    end
                    else
                    begin
                        healthy_acks_next = '0;
                        if (reserve_reg > minimum)
                        begin
                            if ({1'b0, reserve_reg} > floor_plus_step)
                                reserve_next = reserve_reg
                                    - {{(ADM_LINE_W-ADM_STEP_W){1'b0}}, cfg.step_lines};
                            else
                                reserve_next = minimum;
                            reductions_next = reductions_reg + COUNT_BITS'(1);
                        end
                    end
                end
            end
            CMD_PHASE_LOCK:
            begin
                locked_flag_next = 1'b1;
            end
            CMD_SET_AUTOMATIC:
            begin
                if (automatic_on_reg != automatic_value)
                begin
                    automatic_on_next = automatic_value;
                    reserve_next      = conservative;
                    healthy_acks_next = '0;
                end
            end
            CMD_CONFIGURE:
            begin
                captured_total_next = new_total;
                field_mode_on_next  = cfg.field_buffer;
                automatic_on_next   = automatic_value;
                locked_flag_next    = 1'b0;
                reserve_next        = conservative_of(new_total);
                healthy_acks_next   = '0;
                reductions_next     = '0;
                restores_next       = '0;
            end
            CMD_RESET:
            begin
                captured_total_next = '0;
                field_mode_on_next  = 1'b0;
                automatic_on_next   = 1'b0;
                locked_flag_next    = 1'b0;
                reserve_next        = '0;
                healthy_acks_next   = '0;
                reductions_next     = '0;
                restores_next       = '0;
            end
            default:
            begin
                locked_flag_next = locked_flag_reg;
            end
        endcase

        eligible_next = (captured_total_next != '0) && field_mode_on_next
                        && automatic_on_next && locked_flag_next;

        result.eligible_now    = eligible_next;
        result.reserve_lines   = reserve_next;
        result.safe_line       = (captured_total_next != '0)
                                 ? captured_total_next - reserve_next : '0;
        result.healthy_count   = healthy_acks_next;
        result.reduction_count = ADM_STAT_W'(reductions_next);
        result.reset_count     = ADM_STAT_W'(restores_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            captured_total_reg <= '0;
            field_mode_on_reg  <= 1'b0;
            automatic_on_reg   <= 1'b0;
            locked_flag_reg    <= 1'b0;
            reserve_reg        <= '0;
            healthy_acks_reg   <= '0;
            reductions_reg     <= '0;
            restores_reg       <= '0;
        end
        else if (update)
        begin
            captured_total_reg <= captured_total_next;
            field_mode_on_reg  <= field_mode_on_next;
            automatic_on_reg   <= automatic_on_next;
            locked_flag_reg    <= locked_flag_next;
            reserve_reg        <= reserve_next;
            healthy_acks_reg   <= healthy_acks_next;
            reductions_reg     <= reductions_next;
            restores_reg       <= restores_next;
        end
    end

endmodule

FILE: rtl/core/adaptive_delivery_margin.sv
`timescale 1ns / 1ps

// Adaptive delivery margin: keeps a reserve of lines before frame end and
// shrinks it step by step while acknowledgements stay healthy, returning one
// statistics transaction for every command transaction. A command is taken
// into an input register; once the result register is free or being emptied,
// the state update and the new statistics are produced together and stored in
// the result register. One command can be taken every cycle while the output
// is not stalled. A result waiting on the output does not block a command from
// entering an empty input register, but holds a command already there, and so
// the next one. Configuration writes take effect on the next clock edge and
// should only be issued while no command is in flight.

module adaptive_delivery_margin
    import adm_pkg::*;
#(
    parameter int COUNT_BITS = ADM_COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    adm_cmd_if.sink                req,
    adm_stat_if.source             stat,
    input  logic                   cfg_wr_en,
    input  logic [ADM_INDEX_W-1:0] cfg_index,
    input  logic [ADM_DATA_W-1:0]  cfg_data
);

    cfg_t                 cfg;
    result_t              result;
    result_t              result_reg;
    logic                 out_valid_reg;
    logic                 in_valid_reg;
    logic [ADM_CMD_W-1:0] cmd_reg;
    logic                 automatic_value_reg;
    logic                 advance;

    adm_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    adm_margin_state #(
        .COUNT_BITS (COUNT_BITS)
    ) u_margin_state (
        .clk             (clk),
        .rst_n           (rst_n),
        .update          (advance),
        .cmd             (cmd_reg),
        .automatic_value (automatic_value_reg),
        .cfg             (cfg),
        .result          (result)
    );

    // The held command moves on whenever the result register is free or being emptied.
    assign advance   = in_valid_reg && (!out_valid_reg || stat.ready);
    assign req.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_reg             <= req.cmd;
            automatic_value_reg <= req.automatic_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (stat.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign stat.valid           = out_valid_reg;
    assign stat.eligible_now    = result_reg.eligible_now;
    assign stat.reserve_lines   = result_reg.reserve_lines;
    assign stat.safe_line       = result_reg.safe_line;
    assign stat.healthy_count   = result_reg.healthy_count;
    assign stat.reduction_count = result_reg.reduction_count;
    assign stat.reset_count     = result_reg.reset_count;

endmodule

FILE: rtl/core/adm_checker.sv
`timescale 1ns / 1ps

module adm_checker
    import adm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  stat_valid,
    input logic                  stat_ready,
    input logic                  eligible_now,
    input logic [ADM_LINE_W-1:0] reserve_lines,
    input logic [ADM_LINE_W-1:0] safe_line,
    input logic [ADM_HACK_W-1:0] healthy_count,
    input logic [ADM_STAT_W-1:0] reduction_count,
    input logic [ADM_STAT_W-1:0] reset_count
);

    // A stalled result transaction keeps its contents.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid && !stat_ready |=> stat_valid && $stable(eligible_now)
        && $stable(reserve_lines) && $stable(safe_line) && $stable(healthy_count)
        && $stable(reduction_count) && $stable(reset_count))
        else $error("stalled statistics changed");

    // While adapting, the reserve never falls below one line.
    a_reserve_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid && eligible_now |-> reserve_lines != '0)
        else $error("zero reserve while eligible");

    // Healthy acknowledgements are only counted while eligible.
    a_healthy_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid && !eligible_now |-> healthy_count == '0)
        else $error("healthy count held while not eligible");

    // The count always stays below the threshold, which is at most 255.
    a_healthy_range: assert property (@(posedge clk) disable iff (!rst_n)
        stat_valid |-> healthy_count != {ADM_HACK_W{1'b1}})
        else $error("healthy count reached its maximum");

endmodule

bind adaptive_delivery_margin adm_checker u_adm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .stat_valid      (stat.valid),
    .stat_ready      (stat.ready),
    .eligible_now    (stat.eligible_now),
    .reserve_lines   (stat.reserve_lines),
    .safe_line       (stat.safe_line),
    .healthy_count   (stat.healthy_count),
    .reduction_count (stat.reduction_count),
    .reset_count     (stat.reset_count)
);
